### rtl/dual_actuator_sync_controller_assert.svh
// Assertion macros for the dual actuator sync controller.
// Needs nothing else; included by the top level only.
`ifndef DUAL_ACTUATOR_SYNC_CONTROLLER_ASSERT_SVH
`define DUAL_ACTUATOR_SYNC_CONTROLLER_ASSERT_SVH

// Condition implies consequence in the same cycle
`define DASC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition implies consequence in the next cycle
`define DASC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/dasc_pkg.sv
// Shared types and constants of the dual actuator sync controller.
// No dependencies; imported by every module of the block.
package dasc_pkg;

    // Field widths fixed by the word formats
    localparam int OP_W      = 3;
    localparam int SW_W      = 2;
    localparam int LIMIT_W   = 10;
    localparam int GAIN_W    = 8;
    localparam int MARGIN_W  = 4;
    localparam int DUTY_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int LED_W     = 2;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 10;

    // Command codes
    localparam logic [OP_W-1:0] OP_STOP     = 3'd0;
    localparam logic [OP_W-1:0] OP_CLOSE    = 3'd1;
    localparam logic [OP_W-1:0] OP_OPEN     = 3'd2;
    localparam logic [OP_W-1:0] OP_SAMPLE_A = 3'd3;
    localparam logic [OP_W-1:0] OP_SAMPLE_B = 3'd4;
    localparam logic [OP_W-1:0] OP_SWITCH   = 3'd5;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd6;

    // Switch identifiers
    localparam logic [SW_W-1:0] SW_UP_A   = 2'd0;
    localparam logic [SW_W-1:0] SW_DOWN_A = 2'd1;

    // Motion modes
    localparam logic [MODE_W-1:0] MODE_STOP    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPENING = 2'd2;

    // LED patterns
    localparam logic [LED_W-1:0] LED_IDLE    = 2'd0;
    localparam logic [LED_W-1:0] LED_CLOSING = 2'd1;
    localparam logic [LED_W-1:0] LED_OPENING = 2'd2;

    // End status codes
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_A_CLOSED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_A_OPEN   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_B_CLOSED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_B_OPEN   = 3'd4;

    // End flag bit positions
    localparam int FLAG_A_CLOSED = 0;
    localparam int FLAG_A_OPEN   = 1;
    localparam int FLAG_B_CLOSED = 2;
    localparam int FLAG_B_OPEN   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PUSH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 3'd6;

    // Register reset values
    localparam logic [LIMIT_W-1:0]  RST_LOWER_A = 10'd95;
    localparam logic [LIMIT_W-1:0]  RST_UPPER_A = 10'd412;
    localparam logic [LIMIT_W-1:0]  RST_LOWER_B = 10'd60;
    localparam logic [LIMIT_W-1:0]  RST_UPPER_B = 10'd392;
    localparam logic [GAIN_W-1:0]   RST_PUSH    = 8'd45;
    localparam logic [GAIN_W-1:0]   RST_PULL    = 8'd2;
    localparam logic [MARGIN_W-1:0] RST_MARGIN  = 4'd2;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

    // Classified command, front to back
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            off_a;
        logic            off_b;
        logic            window_check;
    } cmd_ctl_t;

    // Result word, first field in the highest bits
    typedef struct packed {
        logic [LED_W-1:0]    led_pattern;
        logic [STATUS_W-1:0] status_code;
        logic [DUTY_W-1:0]   duty_b;
        logic [DUTY_W-1:0]   duty_a;
        logic                direction_open;
        logic                motor_b_on;
        logic                motor_a_on;
    } result_t;

endpackage

### rtl/dasc_front.sv
// Front end: accepts command words and classifies them.
// Depends on dasc_pkg; feeds the command queue.
module dasc_front
    import dasc_pkg::*;
#(
    parameter int POS_W = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [OP_W-1:0]  in_command,
    input  logic [POS_W-1:0] in_position,
    input  logic [SW_W-1:0]  in_switch_id,
    output logic             out_valid,
    input  logic             out_ready,
    output cmd_ctl_t         out_ctl,
    output logic [POS_W-1:0] out_position
);

    logic             valid_reg;
    logic             valid_next;
    cmd_ctl_t         ctl_reg;
    cmd_ctl_t         ctl_next;
    logic [POS_W-1:0] pos_reg;
    logic             take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Decode the switch release into motor actions
    always_comb
    begin
        ctl_next.op           = in_command;
        ctl_next.off_a        = 1'b0;
        ctl_next.off_b        = 1'b0;
        ctl_next.window_check = 1'b0;
        if (in_command == OP_SWITCH)
        begin
            case (in_switch_id)
                SW_UP_A:   ctl_next.off_a        = 1'b1;
                SW_DOWN_A: ctl_next.window_check = 1'b1;
                default:   ctl_next.off_b        = 1'b1;
            endcase
        end
    end

    // Hold the word until the queue takes it
    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctl_reg <= ctl_next;
            pos_reg <= in_position;
        end
    end

    assign out_valid    = valid_reg;
    assign out_ctl      = ctl_reg;
    assign out_position = pos_reg;

endmodule

### rtl/dasc_queue.sv
// Two-entry command queue between front and back end.
// Depends on dasc_pkg only for the house import.
module dasc_queue
    import dasc_pkg::*;
#(
    parameter int DATA_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [DATA_W-1:0] mem [DEPTH];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/dasc_back.sv
// Back end: executes commands on the actuator state and holds the result word.
// Depends on dasc_pkg; holds the configuration registers.
module dasc_back
    import dasc_pkg::*;
#(
    parameter int POS_W = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cmd_ctl_t             in_ctl,
    input  logic [POS_W-1:0]     in_position,
    output logic                 res_valid,
    input  logic                 res_ready,
    output result_t              res
);

    localparam int WIDE_W = ((POS_W > LIMIT_W) ? POS_W : LIMIT_W) + 1;
    localparam int PROD_W = POS_W + GAIN_W;
    localparam int CUT_W  = PROD_W - 4;

    // Configuration
    logic [LIMIT_W-1:0]  lower_a_reg;
    logic [LIMIT_W-1:0]  upper_a_reg;
    logic [LIMIT_W-1:0]  lower_b_reg;
    logic [LIMIT_W-1:0]  upper_b_reg;
    logic [GAIN_W-1:0]   push_gain_reg;
    logic [GAIN_W-1:0]   pull_gain_reg;
    logic [MARGIN_W-1:0] margin_reg;

    // Actuator state
    logic [MODE_W-1:0]   mode_reg,   mode_next;
    logic [1:0]          motor_reg,  motor_next;
    logic                dir_reg,    dir_next;
    logic [POS_W-1:0]    pos_a_reg,  pos_a_next;
    logic [POS_W-1:0]    pos_b_reg,  pos_b_next;
    logic [POS_W-1:0]    diff_reg,   diff_next;
    logic                a_ahead_reg, a_ahead_next;
    logic [DUTY_W-1:0]   duty_a_reg, duty_a_next;
    logic [DUTY_W-1:0]   duty_b_reg, duty_b_next;
    logic [3:0]          flags_reg,  flags_next;
    logic [LED_W-1:0]    led_reg,    led_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                valid_reg,  valid_next;

    logic               pop;
    logic               sel_b;
    logic [POS_W-1:0]   cmp_a;
    logic [POS_W-1:0]   cmp_b;
    logic               cmp_gt;
    logic [WIDE_W-1:0]  pos_w;
    logic [WIDE_W-1:0]  lo_w;
    logic [WIDE_W-1:0]  hi_w;
    logic               below_lo;
    logic               above_hi;
    logic [WIDE_W-1:0]  margin_w;
    logic [WIDE_W-1:0]  win_lo_w;
    logic [WIDE_W-1:0]  win_hi_w;
    logic [WIDE_W-1:0]  pa_w;
    logic [WIDE_W-1:0]  pb_w;
    logic               out_window;
    logic               a_push;
    logic [PROD_W-1:0]  prod_push;
    logic [PROD_W-1:0]  prod_pull;
    logic [DUTY_W-1:0]  duty_push;
    logic [DUTY_W-1:0]  duty_pull;

    assign in_ready = !valid_reg || res_ready;
    assign pop      = in_valid && in_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_a_reg   <= RST_LOWER_A;
            upper_a_reg   <= RST_UPPER_A;
            lower_b_reg   <= RST_LOWER_B;
            upper_b_reg   <= RST_UPPER_B;
            push_gain_reg <= RST_PUSH;
            pull_gain_reg <= RST_PULL;
            margin_reg    <= RST_MARGIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOWER_A: lower_a_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_UPPER_A: upper_a_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_LOWER_B: lower_b_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_UPPER_B: upper_b_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_PUSH:    push_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_PULL:    pull_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_MARGIN:  margin_reg    <= cfg_data[MARGIN_W-1:0];
                default:     ;
            endcase
        end
    end

    // Sample compares against the limits of the sampled actuator
    assign sel_b    = (in_ctl.op == OP_SAMPLE_B);
    assign pos_w    = {{(WIDE_W-POS_W){1'b0}}, in_position};
    assign lo_w     = {{(WIDE_W-LIMIT_W){1'b0}}, sel_b ? lower_b_reg : lower_a_reg};
    assign hi_w     = {{(WIDE_W-LIMIT_W){1'b0}}, sel_b ? upper_b_reg : upper_a_reg};
    assign below_lo = (pos_w < lo_w);
    assign above_hi = (pos_w > hi_w);

    // Track the distance between the actuators as each sample lands
    assign cmp_a  = sel_b ? pos_a_reg : in_position;
    assign cmp_b  = sel_b ? in_position : pos_b_reg;
    assign cmp_gt = (cmp_a > cmp_b);

    // Window around A's limits, widened so nothing wraps
    assign margin_w   = {{(WIDE_W-MARGIN_W){1'b0}}, margin_reg};
    assign win_lo_w   = {{(WIDE_W-LIMIT_W){1'b0}}, lower_a_reg};
    assign win_hi_w   = {{(WIDE_W-LIMIT_W){1'b0}}, upper_a_reg} + margin_w;
    assign pa_w       = {{(WIDE_W-POS_W){1'b0}}, pos_a_reg};
    assign pb_w       = {{(WIDE_W-POS_W){1'b0}}, pos_b_reg};
    assign out_window = (pa_w + margin_w < win_lo_w) || (pa_w > win_hi_w) ||
                        (pb_w + margin_w < win_lo_w) || (pb_w > win_hi_w);

    // Duty cut from the stored distance, Q4.4 gains
    assign prod_push = {{GAIN_W{1'b0}}, diff_reg} * {{POS_W{1'b0}}, push_gain_reg};
    assign prod_pull = {{GAIN_W{1'b0}}, diff_reg} * {{POS_W{1'b0}}, pull_gain_reg};

    always_comb
    begin
        if (prod_push[PROD_W-1:4] >= CUT_W'(DUTY_MAX))
            duty_push = '0;
        else
            duty_push = DUTY_MAX - prod_push[DUTY_W+3:4];
        if (prod_pull[PROD_W-1:4] >= CUT_W'(DUTY_MAX))
            duty_pull = '0;
        else
            duty_pull = DUTY_MAX - prod_pull[DUTY_W+3:4];
    end

    assign a_push = (a_ahead_reg == (mode_reg == MODE_OPENING));

    // Execute one command
    always_comb
    begin
        mode_next    = mode_reg;
        motor_next   = motor_reg;
        dir_next     = dir_reg;
        pos_a_next   = pos_a_reg;
        pos_b_next   = pos_b_reg;
        diff_next    = diff_reg;
        a_ahead_next = a_ahead_reg;
        duty_a_next  = duty_a_reg;
        duty_b_next  = duty_b_reg;
        flags_next   = flags_reg;
        led_next     = led_reg;
        status_next  = STATUS_NONE;
        case (in_ctl.op)
            OP_STOP:
            begin
                mode_next  = MODE_STOP;
                motor_next = 2'b00;
                dir_next   = 1'b0;
                led_next   = LED_IDLE;
            end
            OP_CLOSE:
            begin
                mode_next  = MODE_CLOSING;
                motor_next = 2'b11;
                dir_next   = 1'b0;
                led_next   = LED_CLOSING;
            end
            OP_OPEN:
            begin
                mode_next  = MODE_OPENING;
                motor_next = 2'b11;
                dir_next   = 1'b1;
                led_next   = LED_OPENING;
            end
            OP_SAMPLE_A,
            OP_SAMPLE_B:
            begin
                if (sel_b)
                    pos_b_next = in_position;
                else
                    pos_a_next = in_position;
                a_ahead_next = cmp_gt;
                diff_next    = cmp_gt ? (cmp_a - cmp_b) : (cmp_b - cmp_a);
                if (below_lo && mode_reg == MODE_CLOSING)
                begin
                    motor_next[sel_b] = 1'b0;
                    led_next          = LED_IDLE;
                    if (sel_b && !flags_reg[FLAG_B_CLOSED])
                    begin
                        flags_next[FLAG_B_CLOSED] = 1'b1;
                        flags_next[FLAG_B_OPEN]   = 1'b0;
                        status_next               = STATUS_B_CLOSED;
                    end
                    else if (!sel_b && !flags_reg[FLAG_A_CLOSED])
                    begin
                        flags_next[FLAG_A_CLOSED] = 1'b1;
                        flags_next[FLAG_A_OPEN]   = 1'b0;
                        status_next               = STATUS_A_CLOSED;
                    end
                end
                else if (above_hi && mode_reg == MODE_OPENING)
                begin
                    motor_next[sel_b] = 1'b0;
                    led_next          = LED_IDLE;
                    if (sel_b && !flags_reg[FLAG_B_OPEN])
                    begin
                        flags_next[FLAG_B_OPEN]   = 1'b1;
                        flags_next[FLAG_B_CLOSED] = 1'b0;
                        status_next               = STATUS_B_OPEN;
                    end
                    else if (!sel_b && !flags_reg[FLAG_A_OPEN])
                    begin
                        flags_next[FLAG_A_OPEN]   = 1'b1;
                        flags_next[FLAG_A_CLOSED] = 1'b0;
                        status_next               = STATUS_A_OPEN;
                    end
                end
            end
            OP_SWITCH:
            begin
                if (in_ctl.off_a)
                    motor_next[0] = 1'b0;
                if (in_ctl.off_b)
                    motor_next[1] = 1'b0;
                if (in_ctl.window_check && out_window)
                    motor_next = 2'b00;
            end
            OP_TICK:
            begin
                if ((mode_reg == MODE_CLOSING || mode_reg == MODE_OPENING) &&
                    diff_reg != '0)
                begin
                    duty_a_next = a_push ? duty_push : duty_pull;
                    duty_b_next = a_push ? duty_pull : duty_push;
                end
            end
            default: ;
        endcase
    end

    // Hold the result word until it is taken
    always_comb
    begin
        if (pop)
            valid_next = 1'b1;
        else if (res_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            mode_reg    <= MODE_STOP;
            motor_reg   <= 2'b00;
            dir_reg     <= 1'b0;
            pos_a_reg   <= '0;
            pos_b_reg   <= '0;
            diff_reg    <= '0;
            a_ahead_reg <= 1'b0;
            duty_a_reg  <= DUTY_MAX;
            duty_b_reg  <= DUTY_MAX;
            flags_reg   <= 4'b0000;
            led_reg     <= LED_IDLE;
            status_reg  <= STATUS_NONE;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                mode_reg    <= mode_next;
                motor_reg   <= motor_next;
                dir_reg     <= dir_next;
                pos_a_reg   <= pos_a_next;
                pos_b_reg   <= pos_b_next;
                diff_reg    <= diff_next;
                a_ahead_reg <= a_ahead_next;
                duty_a_reg  <= duty_a_next;
                duty_b_reg  <= duty_b_next;
                flags_reg   <= flags_next;
                led_reg     <= led_next;
                status_reg  <= status_next;
            end
        end
    end

    // State only moves when the word is free, so it is the result
    assign res_valid          = valid_reg;
    assign res.motor_a_on     = motor_reg[0];
    assign res.motor_b_on     = motor_reg[1];
    assign res.direction_open = dir_reg;
    assign res.duty_a         = duty_a_reg;
    assign res.duty_b         = duty_b_reg;
    assign res.status_code    = status_reg;
    assign res.led_pattern    = led_reg;

endmodule

### rtl/dual_actuator_sync_controller.sv
// A word accepted into the front register is written into the queue and then
// registered into the back end result register, which holds the result word.
// Throughput: one word per cycle while m_tready is high; the back end then applies one command per cycle.
// A two-entry queue decouples the front register from the back end result register.
// Reset (rst_n low, asynchronous) empties the pipeline, stops both motors,
// sets both duties to 255, clears positions and end flags, loads register defaults.
`include "dual_actuator_sync_controller_assert.svh"
module dual_actuator_sync_controller
    import dasc_pkg::*;
#(
    parameter int POSITION_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command [2:0], position [POSITION_BITS+2:3], switch_id next, zero fill
    input  logic [((OP_W+POSITION_BITS+SW_W+7)/8)*8-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // motor_a_on, motor_b_on, direction_open, duty_a, duty_b,
    // status_code, led_pattern
    output logic [$bits(result_t)-1:0] m_tdata
);

    localparam int Q_W = $bits(cmd_ctl_t) + POSITION_BITS;

    logic                     fr_valid;
    logic                     fr_ready;
    cmd_ctl_t                 fr_ctl;
    logic [POSITION_BITS-1:0] fr_pos;
    logic                     q_valid;
    logic                     q_ready;
    logic [Q_W-1:0]           q_data;
    cmd_ctl_t                 bk_ctl;
    logic [POSITION_BITS-1:0] bk_pos;
    result_t                  res;
    logic                     a_end_word;
    logic                     b_end_word;

    dasc_front #(
        .POS_W (POSITION_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_command   (s_tdata[OP_W-1:0]),
        .in_position  (s_tdata[OP_W+POSITION_BITS-1:OP_W]),
        .in_switch_id (s_tdata[OP_W+POSITION_BITS+SW_W-1:OP_W+POSITION_BITS]),
        .out_valid    (fr_valid),
        .out_ready    (fr_ready),
        .out_ctl      (fr_ctl),
        .out_position (fr_pos)
    );

    dasc_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  ({fr_ctl, fr_pos}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign bk_ctl = q_data[Q_W-1:POSITION_BITS];
    assign bk_pos = q_data[POSITION_BITS-1:0];

    dasc_back #(
        .POS_W (POSITION_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_ctl      (bk_ctl),
        .in_position (bk_pos),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = res;

    // Result words that carry an end code, per actuator
    assign a_end_word = m_tvalid && (res.status_code == STATUS_A_CLOSED ||
                                     res.status_code == STATUS_A_OPEN);
    assign b_end_word = m_tvalid && (res.status_code == STATUS_B_CLOSED ||
                                     res.status_code == STATUS_B_OPEN);

    // An end code for an actuator always comes with its motor off
    `DASC_ASSERT_IMPL(a_end_stops_a, clk, rst_n, a_end_word, !res.motor_a_on)
    `DASC_ASSERT_IMPL(b_end_stops_b, clk, rst_n, b_end_word, !res.motor_b_on)
    // Opening direction never shows the closing pattern
    `DASC_ASSERT_IMPL(dir_led_agree, clk, rst_n, m_tvalid && res.direction_open, res.led_pattern != LED_CLOSING)
    // A word taken from the queue yields a result word next cycle
    `DASC_ASSERT_NEXT(pop_gives_word, clk, rst_n, q_valid && q_ready, m_tvalid)

endmodule
